### hw/rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and byte codes for the track parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CHAN  = 3'd0,
    KIND_TEXT  = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_EOT   = 3'd3,
    KIND_ERR   = 3'd4
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_LONG_DELTA = 3'd0,
    ERR_NO_RUNNING = 3'd1,
    ERR_BAD_LENGTH = 3'd2,
    ERR_SHORT_PORT = 3'd3,
    ERR_SHORT_TEMPO = 3'd4
  } err_e;

  // Byte class as seen in the status position
  typedef enum logic [2:0] {
    CLS_DATA,
    CLS_CHAN2,
    CLS_CHAN1,
    CLS_SYSEX,
    CLS_META,
    CLS_SYSCOM
  } cls_e;

  // Meta type class as seen in the meta type position
  typedef enum logic [1:0] {
    META_PORT,
    META_EOT,
    META_TEMPO,
    META_TEXT
  } meta_e;

  // Status high nibbles
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_KEY_PRESS = 4'hA;
  localparam logic [3:0] NIB_CTRL      = 4'hB;
  localparam logic [3:0] NIB_PROGRAM   = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
  localparam logic [3:0] NIB_BEND      = 4'hE;

  // Status and meta bytes
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] MT_PORT       = 8'h21;
  localparam logic [7:0] MT_EOT        = 8'h2F;
  localparam logic [7:0] MT_TEMPO      = 8'h51;

  localparam int unsigned VlWidth  = 28;
  localparam logic [VlWidth-1:0] TempoMinLen = 28'd3;

  // One classified byte on its way from front to back
  typedef struct packed {
    logic [7:0] track_byte;
    logic       track_last;
    cls_e       cls;
    meta_e      meta;
  } entry_t;

endpackage

### hw/rtl/mtep_trk_if.sv
// ----------------------------------------------------------------------------
// Track byte channel
// Valid/ready channel carrying one track byte and its last flag.
// ----------------------------------------------------------------------------
interface mtep_trk_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_last;

  modport source (output valid, output track_byte, output track_last, input ready);
  modport sink   (input valid, input track_byte, input track_last, output ready);
endinterface

### hw/rtl/mtep_evt_if.sv
// ----------------------------------------------------------------------------
// Parsed event channel
// Valid/ready channel carrying one parsed event, text byte or error.
// ----------------------------------------------------------------------------
interface mtep_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] tick;
  logic [3:0]  event_type;
  logic [3:0]  channel;
  logic [6:0]  first_param;
  logic [6:0]  second_param;
  logic [7:0]  text_byte;
  logic        text_last;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output tick, output event_type,
                  output channel, output first_param, output second_param,
                  output text_byte, output text_last, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input tick, input event_type,
                  input channel, input first_param, input second_param,
                  input text_byte, input text_last, input error_code,
                  output ready);
endinterface

### hw/rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses the bytes of one MIDI file track into timed channel events.
// ----------------------------------------------------------------------------
// Usage:
//   trk_i carries one track byte per item, with track_last set on the final
//   byte of a track; the parser returns to its start state after that byte.
//   evt_o carries at most one result per byte: a channel event with its tick,
//   one meta text byte, an empty meta text marker, end of track or an error.
//   Bytes that give no result (deltas, headers, skipped payloads) produce
//   nothing on evt_o.
// Timing:
//   A byte is tagged by the front end and written to a two-entry queue; the
//   parse engine takes it from the queue and its result is registered in the
//   output register on evt_o. While evt_o is not stalled, one byte per cycle
//   is sustained, limited by the single-step phase machine, one byte a cycle.
// Reset and stalls:
//   Reset empties the queue, drops any held result and clears tick, running
//   status and parse phase. While evt_o is stalled the result is held in the
//   output register; the engine stops and the queue takes bytes until both
//   of its entries are full, then trk_i.ready drops.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  mtep_trk_if.sink     trk_i,
  mtep_evt_if.source   evt_o
);

  logic              push_valid, push_ready;
  mtep_pkg::entry_t  push_entry;
  logic              pop_valid, pop_ready;
  mtep_pkg::entry_t  pop_entry;

  mtep_front u_front (
    .trk_i        (trk_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  mtep_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  mtep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .evt_o       (evt_o)
  );

endmodule

### hw/rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// Track parser front end
// Accepts track bytes and tags each with its status and meta class.
// ----------------------------------------------------------------------------
module mtep_front (
  mtep_trk_if.sink          trk_i,
  input  logic              push_ready_i,
  output logic              push_valid_o,
  output mtep_pkg::entry_t  push_entry_o
);

  logic [7:0]       b;
  mtep_pkg::cls_e   cls;
  mtep_pkg::meta_e  meta;

  assign b = trk_i.track_byte;

  always_comb begin
    cls = mtep_pkg::CLS_SYSCOM;
    if (!b[7]) begin
      cls = mtep_pkg::CLS_DATA;
    end else begin
      unique case (b[7:4]) inside
        mtep_pkg::NIB_NOTE_OFF, mtep_pkg::NIB_NOTE_ON, mtep_pkg::NIB_KEY_PRESS,
        mtep_pkg::NIB_CTRL, mtep_pkg::NIB_BEND: begin
          cls = mtep_pkg::CLS_CHAN2;
        end
        mtep_pkg::NIB_PROGRAM, mtep_pkg::NIB_CHAN_PRESS: begin
          cls = mtep_pkg::CLS_CHAN1;
        end
        default: begin
          if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_CONT) begin
            cls = mtep_pkg::CLS_SYSEX;
          end else if (b == mtep_pkg::ST_META) begin
            cls = mtep_pkg::CLS_META;
          end else begin
            cls = mtep_pkg::CLS_SYSCOM;
          end
        end
      endcase
    end
  end

  always_comb begin
    unique case (b)
      mtep_pkg::MT_PORT:  meta = mtep_pkg::META_PORT;
      mtep_pkg::MT_EOT:   meta = mtep_pkg::META_EOT;
      mtep_pkg::MT_TEMPO: meta = mtep_pkg::META_TEMPO;
      default:            meta = mtep_pkg::META_TEXT;
    endcase
  end

  assign push_valid_o            = trk_i.valid;
  assign trk_i.ready             = push_ready_i;
  assign push_entry_o.track_byte = b;
  assign push_entry_o.track_last = trk_i.track_last;
  assign push_entry_o.cls        = cls;
  assign push_entry_o.meta       = meta;

endmodule

### hw/rtl/mtep_fifo.sv
// ----------------------------------------------------------------------------
// Track parser byte queue
// Two-entry queue between front end and parse engine.
// ----------------------------------------------------------------------------
module mtep_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  mtep_pkg::entry_t  push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output mtep_pkg::entry_t  pop_entry_o
);

  localparam logic [1:0] Depth = 2'd2;

  mtep_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != Depth);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### hw/rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// Track parser engine
// Runs the parse phase machine on queued bytes and holds the output event.
// ----------------------------------------------------------------------------
module mtep_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  mtep_pkg::entry_t  pop_entry_i,
  mtep_evt_if.source        evt_o
);

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_ONE,
    PH_SYSLEN,
    PH_SKIP,
    PH_MTYPE,
    PH_MLEN,
    PH_TEXT,
    PH_DONE
  } phase_e;

  localparam int unsigned VW = mtep_pkg::VlWidth;

  phase_e              phase_q, phase_d;
  logic [31:0]         tick_q, tick_d;
  logic [7:0]          run_st_q, run_st_d;
  logic [7:0]          cur_st_q, cur_st_d;
  logic [VW-1:0]       vl_val_q, vl_val_d;
  logic [2:0]          vl_cnt_q, vl_cnt_d;
  logic [VW-1:0]       left_q, left_d;
  mtep_pkg::meta_e     meta_q, meta_d;
  logic [6:0]          held_q, held_d;

  logic                out_vld_q, out_vld_d;
  mtep_pkg::kind_e     kind_q, kind_d;
  logic [31:0]         otick_q, otick_d;
  logic [3:0]          etype_q, etype_d;
  logic [3:0]          chan_q, chan_d;
  logic [6:0]          p1_q, p1_d;
  logic [6:0]          p2_q, p2_d;
  logic [7:0]          txt_q, txt_d;
  logic                txt_last_q, txt_last_d;
  mtep_pkg::err_e      err_q, err_d;

  logic                pop;
  logic [7:0]          b;
  logic                vl_long;
  logic [VW-1:0]       vl_next;
  logic [VW-1:0]       left_dec;
  logic                res_vld;

  assign pop_ready_o = !out_vld_q || evt_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign b           = pop_entry_i.track_byte;
  assign vl_long     = vl_cnt_q[2];
  assign vl_next     = {vl_val_q[VW-8:0], b[6:0]};
  assign left_dec    = left_q - {{(VW-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    run_st_d   = run_st_q;
    cur_st_d   = cur_st_q;
    vl_val_d   = vl_val_q;
    vl_cnt_d   = vl_cnt_q;
    left_d     = left_q;
    meta_d     = meta_q;
    held_d     = held_q;

    res_vld    = 1'b0;
    kind_d     = mtep_pkg::KIND_CHAN;
    otick_d    = tick_q;
    etype_d    = 4'd0;
    chan_d     = 4'd0;
    p1_d       = 7'd0;
    p2_d       = 7'd0;
    txt_d      = 8'd0;
    txt_last_d = 1'b0;
    err_d      = mtep_pkg::ERR_LONG_DELTA;

    if (pop) begin
      unique case (phase_q)
        PH_DELTA: begin
          if (vl_long) begin
            res_vld = 1'b1;
            kind_d  = mtep_pkg::KIND_ERR;
            err_d   = mtep_pkg::ERR_LONG_DELTA;
            phase_d = PH_DONE;
          end else begin
            vl_val_d = vl_next;
            vl_cnt_d = vl_cnt_q + 3'd1;
            if (!b[7]) begin
              tick_d  = tick_q + {{(32-VW){1'b0}}, vl_next};
              phase_d = PH_STATUS;
            end
          end
        end
        PH_STATUS: begin
          unique case (pop_entry_i.cls)
            mtep_pkg::CLS_DATA: begin
              if (run_st_q == 8'd0) begin
                res_vld = 1'b1;
                kind_d  = mtep_pkg::KIND_ERR;
                err_d   = mtep_pkg::ERR_NO_RUNNING;
                phase_d = PH_DONE;
              end else begin
                cur_st_d = run_st_q;
                if (run_st_q[7:4] == mtep_pkg::NIB_PROGRAM ||
                    run_st_q[7:4] == mtep_pkg::NIB_CHAN_PRESS) begin
                  phase_d  = PH_DELTA;
                  vl_val_d = '0;
                  vl_cnt_d = 3'd0;
                end else begin
                  held_d  = b[6:0];
                  phase_d = PH_DATA2;
                end
              end
            end
            mtep_pkg::CLS_CHAN2: begin
              run_st_d = b;
              cur_st_d = b;
              phase_d  = PH_DATA1;
            end
            mtep_pkg::CLS_CHAN1: begin
              run_st_d = b;
              cur_st_d = b;
              phase_d  = PH_ONE;
            end
            mtep_pkg::CLS_SYSEX: begin
              phase_d  = PH_SYSLEN;
              vl_val_d = '0;
              vl_cnt_d = 3'd0;
            end
            mtep_pkg::CLS_META: begin
              phase_d = PH_MTYPE;
            end
            default: begin
              // lone system byte: no data, running status kept
              phase_d  = PH_DELTA;
              vl_val_d = '0;
              vl_cnt_d = 3'd0;
            end
          endcase
        end
        PH_DATA1: begin
          held_d  = b[6:0];
          phase_d = PH_DATA2;
        end
        PH_DATA2: begin
          res_vld  = 1'b1;
          kind_d   = mtep_pkg::KIND_CHAN;
          etype_d  = cur_st_q[7:4];
          chan_d   = cur_st_q[3:0];
          p1_d     = held_q;
          p2_d     = b[6:0];
          phase_d  = PH_DELTA;
          vl_val_d = '0;
          vl_cnt_d = 3'd0;
        end
        PH_ONE: begin
          phase_d  = PH_DELTA;
          vl_val_d = '0;
          vl_cnt_d = 3'd0;
        end
        PH_SYSLEN: begin
          if (vl_long) begin
            res_vld = 1'b1;
            kind_d  = mtep_pkg::KIND_ERR;
            err_d   = mtep_pkg::ERR_BAD_LENGTH;
            phase_d = PH_DONE;
          end else begin
            vl_val_d = vl_next;
            vl_cnt_d = vl_cnt_q + 3'd1;
            if (!b[7]) begin
              left_d = vl_next;
              if (vl_next == '0) begin
                phase_d  = PH_DELTA;
                vl_val_d = '0;
                vl_cnt_d = 3'd0;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d  = PH_DELTA;
            vl_val_d = '0;
            vl_cnt_d = 3'd0;
          end
        end
        PH_MTYPE: begin
          meta_d   = pop_entry_i.meta;
          vl_val_d = '0;
          vl_cnt_d = 3'd0;
          phase_d  = PH_MLEN;
        end
        PH_MLEN: begin
          if (vl_long) begin
            res_vld = 1'b1;
            kind_d  = mtep_pkg::KIND_ERR;
            err_d   = mtep_pkg::ERR_BAD_LENGTH;
            phase_d = PH_DONE;
          end else begin
            vl_val_d = vl_next;
            vl_cnt_d = vl_cnt_q + 3'd1;
            if (!b[7]) begin
              unique case (meta_q)
                mtep_pkg::META_PORT: begin
                  if (vl_next == '0) begin
                    res_vld = 1'b1;
                    kind_d  = mtep_pkg::KIND_ERR;
                    err_d   = mtep_pkg::ERR_SHORT_PORT;
                    phase_d = PH_DONE;
                  end else begin
                    left_d  = vl_next;
                    phase_d = PH_SKIP;
                  end
                end
                mtep_pkg::META_EOT: begin
                  res_vld = 1'b1;
                  kind_d  = mtep_pkg::KIND_EOT;
                  phase_d = PH_DONE;
                end
                mtep_pkg::META_TEMPO: begin
                  if (vl_next < mtep_pkg::TempoMinLen) begin
                    res_vld = 1'b1;
                    kind_d  = mtep_pkg::KIND_ERR;
                    err_d   = mtep_pkg::ERR_SHORT_TEMPO;
                    phase_d = PH_DONE;
                  end else begin
                    left_d  = vl_next;
                    phase_d = PH_SKIP;
                  end
                end
                default: begin
                  if (vl_next == '0) begin
                    res_vld  = 1'b1;
                    kind_d   = mtep_pkg::KIND_EMPTY;
                    phase_d  = PH_DELTA;
                    vl_val_d = '0;
                    vl_cnt_d = 3'd0;
                  end else begin
                    left_d  = vl_next;
                    phase_d = PH_TEXT;
                  end
                end
              endcase
            end
          end
        end
        PH_TEXT: begin
          left_d     = left_dec;
          res_vld    = 1'b1;
          kind_d     = mtep_pkg::KIND_TEXT;
          txt_d      = b;
          txt_last_d = (left_dec == '0) || pop_entry_i.track_last;
          if (left_dec == '0) begin
            phase_d  = PH_DELTA;
            vl_val_d = '0;
            vl_cnt_d = 3'd0;
          end
        end
        default: begin
          // track finished or failed: drop bytes until the last one
        end
      endcase

      if (pop_entry_i.track_last) begin
        phase_d  = PH_DELTA;
        tick_d   = '0;
        run_st_d = '0;
        cur_st_d = '0;
        vl_val_d = '0;
        vl_cnt_d = 3'd0;
        left_d   = '0;
        meta_d   = mtep_pkg::META_PORT;
        held_d   = '0;
      end
    end

    if (pop && res_vld) begin
      out_vld_d = 1'b1;
    end else if (evt_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DELTA;
      tick_q     <= '0;
      run_st_q   <= '0;
      cur_st_q   <= '0;
      vl_val_q   <= '0;
      vl_cnt_q   <= 3'd0;
      left_q     <= '0;
      meta_q     <= mtep_pkg::META_PORT;
      held_q     <= '0;
      out_vld_q  <= 1'b0;
      kind_q     <= mtep_pkg::KIND_CHAN;
      otick_q    <= '0;
      etype_q    <= '0;
      chan_q     <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
      txt_q      <= '0;
      txt_last_q <= 1'b0;
      err_q      <= mtep_pkg::ERR_LONG_DELTA;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      run_st_q  <= run_st_d;
      cur_st_q  <= cur_st_d;
      vl_val_q  <= vl_val_d;
      vl_cnt_q  <= vl_cnt_d;
      left_q    <= left_d;
      meta_q    <= meta_d;
      held_q    <= held_d;
      out_vld_q <= out_vld_d;
      // load the output register only with a fresh result
      if (pop && res_vld) begin
        kind_q     <= kind_d;
        otick_q    <= otick_d;
        etype_q    <= etype_d;
        chan_q     <= chan_d;
        p1_q       <= p1_d;
        p2_q       <= p2_d;
        txt_q      <= txt_d;
        txt_last_q <= txt_last_d;
        err_q      <= err_d;
      end
    end
  end

  assign evt_o.valid        = out_vld_q;
  assign evt_o.kind         = kind_q;
  assign evt_o.tick         = otick_q;
  assign evt_o.event_type   = etype_q;
  assign evt_o.channel      = chan_q;
  assign evt_o.first_param  = p1_q;
  assign evt_o.second_param = p2_q;
  assign evt_o.text_byte    = txt_q;
  assign evt_o.text_last    = txt_last_q;
  assign evt_o.error_code   = (kind_q == mtep_pkg::KIND_ERR) ? err_q : 3'd0;

endmodule

### hw/rtl/mtep_checker.sv
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level properties of the parser output, bound to the top level.
// ----------------------------------------------------------------------------
module mtep_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        evt_valid_i,
  input logic        evt_ready_i,
  input logic [2:0]  evt_kind_i,
  input logic [31:0] evt_tick_i,
  input logic [3:0]  evt_event_type_i,
  input logic [7:0]  evt_text_byte_i,
  input logic        evt_text_last_i,
  input logic [2:0]  evt_error_code_i
);

  // channel events carry only the five forwarded status types
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_kind_i == mtep_pkg::KIND_CHAN |->
      evt_event_type_i == mtep_pkg::NIB_NOTE_OFF ||
      evt_event_type_i == mtep_pkg::NIB_NOTE_ON ||
      evt_event_type_i == mtep_pkg::NIB_KEY_PRESS ||
      evt_event_type_i == mtep_pkg::NIB_CTRL ||
      evt_event_type_i == mtep_pkg::NIB_BEND)
    else $error("channel event with unexpected type");

  // text fields stay clear outside text results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_kind_i != mtep_pkg::KIND_TEXT |->
      evt_text_byte_i == 8'd0 && !evt_text_last_i)
    else $error("text fields set on a non-text result");

  // error code is zero unless the result is an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_kind_i != mtep_pkg::KIND_ERR |-> evt_error_code_i == 3'd0)
    else $error("error code set on a non-error result");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=>
      evt_valid_i && $stable(evt_tick_i) && $stable(evt_kind_i))
    else $error("stalled result changed");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .evt_valid_i      (evt_o.valid),
  .evt_ready_i      (evt_o.ready),
  .evt_kind_i       (evt_o.kind),
  .evt_tick_i       (evt_o.tick),
  .evt_event_type_i (evt_o.event_type),
  .evt_text_byte_i  (evt_o.text_byte),
  .evt_text_last_i  (evt_o.text_last),
  .evt_error_code_i (evt_o.error_code)
);
